FILE: rtl/core/ofdm_pkg.sv
// Package for the 64-point IFFT cyclic prefix modulator: widths, types, twiddles, rounding.
package ofdm_pkg;

	localparam int FFT_POINTS   = 64;
	localparam int PREFIX_LEN   = 16;
	localparam int TWIDDLE_BITS = 16;

	localparam int SAMPLE_W = 16;
	localparam int ADDR_W   = $clog2(FFT_POINTS);
	localparam int STAGES   = ADDR_W;
	localparam int FRAC_W   = 7;
	localparam int DATA_W   = 24;
	localparam int TW_W     = TWIDDLE_BITS + 1;
	localparam int PROD_W   = DATA_W + TW_W;
	localparam int VSUM_W   = PROD_W + 1;
	localparam int SUM_W    = PROD_W + 2;
	localparam int TOTAL    = FFT_POINTS + PREFIX_LEN;
	localparam int PAIRS    = (TOTAL + 1) / 2;
	localparam int PAIR_W   = $clog2(PAIRS);
	localparam int N_W      = PAIR_W + 1;
	localparam int BF_W     = ADDR_W - 1;
	localparam int STAGE_W  = $clog2(STAGES);
	localparam int SAT_MAX  = 32767;

	localparam longint QWAVE [17] = '{
		1073741824, 1068571464, 1053110176, 1027506862, 991908094,
		946955747, 892783698, 830013654, 759250125, 681174602,
		596538995, 506158392, 410903207, 311690799, 209476638,
		105245103, 0
	};

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_BF_RD,
		ST_BF_MUL,
		ST_BF_ADD,
		ST_BF_WA,
		ST_BF_WB,
		ST_OUT_RD,
		ST_OUT_LD
	} state_t;

	typedef struct packed {
		logic signed [TW_W-1:0] c;
		logic signed [TW_W-1:0] s;
	} twiddle_t;

	typedef logic signed [DATA_W-1:0]   data_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;

	function automatic longint rnd_shift_l(longint x, int s);
		longint half;
		half = longint'(1) <<< (s - 1);
		if (x >= 0)
			return (x + half) >>> s;
		return -((-x + half) >>> s);
	endfunction

	function automatic twiddle_t twiddle(logic [BF_W-1:0] k);
		longint cq;
		longint sq;
		int ki;
		twiddle_t t;
		ki = int'(k);
		if (ki <= 16) begin
			cq = QWAVE[ki];
			sq = QWAVE[16 - ki];
		end else begin
			cq = -QWAVE[32 - ki];
			sq = QWAVE[ki - 16];
		end
		t.c = TW_W'(rnd_shift_l(cq, 31 - TWIDDLE_BITS));
		t.s = TW_W'(rnd_shift_l(sq, 31 - TWIDDLE_BITS));
		return t;
	endfunction

	function automatic logic [ADDR_W-1:0] bitrev(logic [ADDR_W-1:0] v);
		logic [ADDR_W-1:0] r;
		for (int b = 0; b < ADDR_W; b++)
			r[ADDR_W-1-b] = v[b];
		return r;
	endfunction

	// Shift right by TWIDDLE_BITS, rounding half away from zero.
	function automatic data_t bfly_round(logic signed [SUM_W-1:0] x);
		logic [SUM_W-1:0] mag;
		logic [SUM_W-1:0] r;
		mag = x[SUM_W-1] ? SUM_W'(-x) : SUM_W'(x);
		r   = (mag + (SUM_W'(1) << (TWIDDLE_BITS - 1))) >> TWIDDLE_BITS;
		return x[SUM_W-1] ? DATA_W'(-r) : DATA_W'(r);
	endfunction

	// Drop the fraction bits with rounding, then clamp to the symmetric range.
	function automatic sample_t out_round(data_t w);
		logic [DATA_W:0] mag;
		logic [DATA_W:0] r;
		mag = w[DATA_W-1] ? (DATA_W+1)'(-w) : (DATA_W+1)'(w);
		r   = (mag + (DATA_W+1)'(1 << (FRAC_W - 1))) >> FRAC_W;
		if (r > (DATA_W+1)'(SAT_MAX))
			r = (DATA_W+1)'(SAT_MAX);
		return w[DATA_W-1] ? SAMPLE_W'(-r) : SAMPLE_W'(r);
	endfunction

endpackage

FILE: rtl/core/ofdm_ifc.sv
// Handshake channels for subcarriers in and time-sample pairs out.
interface ofdm_carrier_if;
	logic                            valid;
	logic                            ready;
	logic signed [ofdm_pkg::SAMPLE_W-1:0] sub_i;
	logic signed [ofdm_pkg::SAMPLE_W-1:0] sub_q;

	modport source (output valid, output sub_i, output sub_q, input ready);
	modport sink   (input valid, input sub_i, input sub_q, output ready);
endinterface

interface ofdm_pair_if;
	logic                            valid;
	logic                            ready;
	logic signed [ofdm_pkg::SAMPLE_W-1:0] first_i;
	logic signed [ofdm_pkg::SAMPLE_W-1:0] first_q;
	logic signed [ofdm_pkg::SAMPLE_W-1:0] second_i;
	logic signed [ofdm_pkg::SAMPLE_W-1:0] second_q;
	logic                            symbol_end;

	modport source (output valid, output first_i, output first_q, output second_i,
		output second_q, output symbol_end, input ready);
	modport sink   (input valid, input first_i, input first_q, input second_i,
		input second_q, input symbol_end, output ready);
endinterface

FILE: rtl/core/ofdm_ifft64_cp_modulator_unit.sv
// 64-point IFFT modulator with cyclic prefix around one shared work memory.
// After the 64th subcarrier beat the transform runs 192 butterflies, each through
// the five steps read, multiply, add, write A and write B, as both results share
// the single write port of the work memory; then each pair is read and loaded,
// holding while the output is stalled. New subcarriers wait for the last pair.
// Reset clears the sequencer, counters and output valid; the memory is not cleared.
module ofdm_ifft64_cp_modulator_unit (
	input  logic       clk,
	input  logic       arst_n,
	ofdm_carrier_if.sink carrier,
	ofdm_pair_if.source  sample
);
	import ofdm_pkg::*;

	state_t state_q, state_d;

	logic [2*DATA_W-1:0] work_mem [FFT_POINTS];

	logic [ADDR_W-1:0]  cnt_q;
	logic [STAGE_W-1:0] stage_q;
	logic [BF_W-1:0]    bf_q;
	logic [PAIR_W-1:0]  pair_q;
	logic               ov_q;

	data_t rd_a_i_q, rd_a_q_q, rd_b_i_q, rd_b_q_q;
	logic signed [PROD_W-1:0] p_rc_q, p_qs_q, p_rs_q, p_qc_q;
	logic signed [VSUM_W-1:0] vr_q, vi_q;

	logic                rd_en, wr_en;
	logic [ADDR_W-1:0]   rd_addr_a, rd_addr_b, wr_addr;
	logic [2*DATA_W-1:0] wr_data;
	logic                in_take, out_load;

	logic [ADDR_W-1:0] lo_mask, bf_ext, a_addr, b_addr;
	logic [BF_W-1:0]   tw_k;
	twiddle_t          tw;
	logic [N_W-1:0]    n0;
	logic [ADDR_W-1:0] idx0, idx1;
	data_t             in_i_ext, in_q_ext;
	logic signed [SUM_W-1:0] ur_i, ur_q, sum_ai, sum_aq, sum_bi, sum_bq;

	assign lo_mask = ADDR_W'((1 << stage_q) - 1);
	assign bf_ext  = {1'b0, bf_q};
	assign a_addr  = ((bf_ext & ~lo_mask) << 1) | (bf_ext & lo_mask);
	assign b_addr  = a_addr | ADDR_W'(1 << stage_q);
	assign tw_k    = BF_W'((bf_ext & lo_mask) << (STAGES - 1 - stage_q));
	assign tw      = twiddle(tw_k);

	assign n0   = {pair_q, 1'b0};
	assign idx0 = ADDR_W'(n0 + N_W'(FFT_POINTS - PREFIX_LEN));
	assign idx1 = ADDR_W'(n0 + N_W'(FFT_POINTS - PREFIX_LEN + 1));

	assign in_i_ext = {{(DATA_W-SAMPLE_W-FRAC_W){carrier.sub_i[SAMPLE_W-1]}},
		carrier.sub_i, FRAC_W'(0)};
	assign in_q_ext = {{(DATA_W-SAMPLE_W-FRAC_W){carrier.sub_q[SAMPLE_W-1]}},
		carrier.sub_q, FRAC_W'(0)};

	assign ur_i   = SUM_W'(rd_a_i_q) <<< (TWIDDLE_BITS - 1);
	assign ur_q   = SUM_W'(rd_a_q_q) <<< (TWIDDLE_BITS - 1);
	assign sum_ai = ur_i + SUM_W'(vr_q);
	assign sum_aq = ur_q + SUM_W'(vi_q);
	assign sum_bi = ur_i - SUM_W'(vr_q);
	assign sum_bq = ur_q - SUM_W'(vi_q);

	assign carrier.ready = (state_q == ST_LOAD);
	assign in_take       = carrier.valid && carrier.ready;

	always_comb begin
		state_d   = state_q;
		rd_en     = 1'b0;
		wr_en     = 1'b0;
		rd_addr_a = a_addr;
		rd_addr_b = b_addr;
		wr_addr   = a_addr;
		wr_data   = {bfly_round(sum_ai), bfly_round(sum_aq)};
		out_load  = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				wr_addr = bitrev({~cnt_q[ADDR_W-1], cnt_q[ADDR_W-2:0]});
				wr_data = {in_i_ext, in_q_ext};
				wr_en   = in_take;
				if (in_take && cnt_q == ADDR_W'(FFT_POINTS - 1))
					state_d = ST_BF_RD;
			end
			ST_BF_RD: begin
				rd_en   = 1'b1;
				state_d = ST_BF_MUL;
			end
			ST_BF_MUL: state_d = ST_BF_ADD;
			ST_BF_ADD: state_d = ST_BF_WA;
			ST_BF_WA: begin
				wr_en   = 1'b1;
				state_d = ST_BF_WB;
			end
			ST_BF_WB: begin
				wr_en   = 1'b1;
				wr_addr = b_addr;
				wr_data = {bfly_round(sum_bi), bfly_round(sum_bq)};
				if (bf_q == BF_W'(FFT_POINTS / 2 - 1) && stage_q == STAGE_W'(STAGES - 1))
					state_d = ST_OUT_RD;
				else
					state_d = ST_BF_RD;
			end
			ST_OUT_RD: begin
				rd_addr_a = idx0;
				rd_addr_b = idx1;
				// hold until the output register is free or being taken
				if (!ov_q || sample.ready) begin
					rd_en   = 1'b1;
					state_d = ST_OUT_LD;
				end
			end
			ST_OUT_LD: begin
				out_load = 1'b1;
				state_d  = (pair_q == PAIR_W'(PAIRS - 1)) ? ST_LOAD : ST_OUT_RD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_LOAD;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			work_mem[wr_addr] <= wr_data;
		if (rd_en) begin
			{rd_a_i_q, rd_a_q_q} <= work_mem[rd_addr_a];
			{rd_b_i_q, rd_b_q_q} <= work_mem[rd_addr_b];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_BF_MUL) begin
			p_rc_q <= PROD_W'(rd_b_i_q * tw.c);
			p_qs_q <= PROD_W'(rd_b_q_q * tw.s);
			p_rs_q <= PROD_W'(rd_b_i_q * tw.s);
			p_qc_q <= PROD_W'(rd_b_q_q * tw.c);
		end
		if (state_q == ST_BF_ADD) begin
			vr_q <= VSUM_W'(p_rc_q) - VSUM_W'(p_qs_q);
			vi_q <= VSUM_W'(p_rs_q) + VSUM_W'(p_qc_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			stage_q <= '0;
			bf_q    <= '0;
			pair_q  <= '0;
		end else begin
			if (in_take)
				cnt_q <= cnt_q + 1'b1;
			if (state_q == ST_BF_WB) begin
				bf_q <= bf_q + 1'b1;
				if (bf_q == BF_W'(FFT_POINTS / 2 - 1))
					stage_q <= (stage_q == STAGE_W'(STAGES - 1)) ? '0 : stage_q + 1'b1;
			end
			if (out_load)
				pair_q <= (pair_q == PAIR_W'(PAIRS - 1)) ? '0 : pair_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ov_q <= 1'b0;
		else if (out_load)
			ov_q <= 1'b1;
		else if (sample.ready)
			ov_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sample.first_i    <= out_round(rd_a_i_q);
			sample.first_q    <= out_round(rd_a_q_q);
			sample.second_i   <= out_round(rd_b_i_q);
			sample.second_q   <= out_round(rd_b_q_q);
			sample.symbol_end <= (pair_q == PAIR_W'(PAIRS - 1));
		end
	end

	assign sample.valid = ov_q;

endmodule

FILE: rtl/core/ofdm_chk.sv
// Port-level checks for the modulator, bound to the top level.
module ofdm_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [ofdm_pkg::SAMPLE_W-1:0] first_i,
	input logic [ofdm_pkg::SAMPLE_W-1:0] second_q,
	input logic out_end
);
	import ofdm_pkg::*;

	logic [ADDR_W-1:0] in_cnt_q;
	logic [PAIR_W-1:0] out_cnt_q;
	logic in_beat, out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q  <= '0;
			out_cnt_q <= '0;
		end else begin
			if (in_beat)
				in_cnt_q <= in_cnt_q + 1'b1;
			if (out_beat)
				out_cnt_q <= out_end ? '0 : out_cnt_q + 1'b1;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(first_i) && $stable(out_end))
		else $error("output beat changed while stalled");

	a_end_place: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat |-> (out_end == (out_cnt_q == PAIR_W'(PAIRS - 1))))
		else $error("symbol end on wrong beat");

	a_busy_after_symbol: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && in_cnt_q == ADDR_W'(FFT_POINTS - 1) |=> !in_ready)
		else $error("input taken during transform");

	a_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> first_i != 16'h8000 && second_q != 16'h8000)
		else $error("sample outside symmetric range");

endmodule

bind ofdm_ifft64_cp_modulator_unit ofdm_chk u_ofdm_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (carrier.valid),
	.in_ready  (carrier.ready),
	.out_valid (sample.valid),
	.out_ready (sample.ready),
	.first_i   (sample.first_i),
	.second_q  (sample.second_q),
	.out_end   (sample.symbol_end)
);
